// File: hdl/rssi_antenna_pan_steering_defines.svh
// Assertion macros shared by the pan steering RTL.
// Each macro expects a clock named clock and a synchronous reset named reset in scope.
`ifndef RSSI_ANTENNA_PAN_STEERING_DEFINES_SVH
`define RSSI_ANTENNA_PAN_STEERING_DEFINES_SVH

// Condition and consequence checked at the same clock edge.
`define RAP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence checked at the clock edge after the condition.
`define RAP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rssi_aps_pkg.sv
// Shared constants, types and elaboration-time table functions for the pan steering block.
// No dependencies; used by every module of the block.
`default_nettype none

package rssi_aps_pkg;

   // Field widths.
   localparam int RSSI_W  = 10;
   localparam int ANGLE_W = 8;
   localparam int STEP_W  = 9;
   localparam int DIFF_W  = 12;

   // Stream and register port widths.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_MIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_MAX = 2'd3;

   // Reset values.
   localparam logic [ANGLE_W-1:0] ANGLE_RESET     = 8'd90;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX_RESET = 8'd180;

   // Parameter defaults.
   localparam int WINDOW_DEFAULT    = 10;
   localparam int SLOPE_Q8_DEFAULT  = 128;
   localparam int OFFSET_Q8_DEFAULT = 0;
   localparam int MAX_STEP_DEFAULT  = 180;

   // ln 2 in Q32.
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;

   // Steering decision carried down the pipeline.
   typedef struct packed {
      logic fire;
      logic left;
   } steer_type;

   // log2(k) in Q16; the fraction comes from 16 rounds of truncated squaring in Q30.
   function automatic logic [31:0] log2_q16(input logic [31:0] k);
      logic [31:0] n;
      logic [31:0] frac;
      logic [63:0] y;
      n    = 32'd0;
      frac = 32'd0;
      for (int i = 0; i < 30; i++) begin
         if ((k >> (n + 32'd1)) != 32'd0) begin
            n = n + 32'd1;
         end
      end
      y = ({32'd0, k} << (32'd30 - n)) & 64'h7FFF_FFFF;
      for (int i = 0; i < 16; i++) begin
         y    = (y * y) >> 30;
         frac = frac << 1;
         if (y >= 64'h8000_0000) begin
            y    = y >> 1;
            frac = frac | 32'd1;
         end
      end
      return (n << 16) | frac;
   endfunction

   // Exponent threshold for step k, in units of 1/2560, rounded up.
   function automatic logic [31:0] step_threshold(input int k);
      logic [63:0] p;
      p = {32'd0, log2_q16(32'(k))} * 64'd2560 * LN2_Q32;
      return 32'((p + ((64'd1 << 48) - 64'd1)) >> 48);
   endfunction

endpackage

`default_nettype wire

// File: hdl/rssi_aps_channel.sv
// One antenna channel: sample window with running sum, running minimum and the mean.
// Depends on rssi_aps_pkg.
`default_nettype none

module rssi_aps_channel #(
   parameter int WINDOW = rssi_aps_pkg::WINDOW_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire logic [rssi_aps_pkg::RSSI_W-1:0]  sample,
   output logic      [rssi_aps_pkg::RSSI_W-1:0]  prev_sample,
   output logic      [rssi_aps_pkg::RSSI_W-1:0]  level
);

   localparam int RSSI_W = rssi_aps_pkg::RSSI_W;
   localparam int SUM_W  = $clog2(WINDOW * ((1 << RSSI_W) - 1) + 1);
   // Reciprocal scale: the rounding error times the largest sum stays below 2^SH.
   localparam int SH     = SUM_W + 6;
   localparam int PROD_W = SUM_W + SH;
   localparam logic [SH-1:0] RECIP =
      SH'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic [RSSI_W-1:0] win_ff [WINDOW];
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [RSSI_W-1:0] floor_ff;
   logic [RSSI_W-1:0] floor_in;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [RSSI_W-1:0] floor_cp_ff;
   logic [RSSI_W-1:0] mean;

   // The newest stored sample is the previous one for this item.
   assign prev_sample = win_ff[WINDOW-1];

   // Running sum drops the oldest sample and adds the new one.
   assign sum_in = SUM_W'({1'b0, sum_ff} + (SUM_W+1)'(sample) - (SUM_W+1)'(win_ff[0]));

   // Divide by the window depth through the reciprocal; the quotient sits above bit SH.
   assign prod_in = {{SH{1'b0}}, sum_in} * {{SUM_W{1'b0}}, RECIP};

   // Running minimum, where zero means not yet set.
   assign floor_in = ((sample <= floor_ff) || (floor_ff == '0)) ? sample : floor_ff;

   // Window, sum and minimum advance on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff   <= '0;
         floor_ff <= '0;
      end else if (push) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WINDOW-1] <= sample;
         sum_ff           <= sum_in;
         floor_ff         <= floor_in;
      end
   end

   // Product and updated minimum are held for the next stage.
   always_ff @(posedge clock) begin
      if (push) begin
         prod_ff     <= prod_in;
         floor_cp_ff <= floor_in;
      end
   end

   // Mean floored at the running minimum.
   assign mean  = prod_ff[SH +: RSSI_W];
   assign level = (mean < floor_cp_ff) ? floor_cp_ff : mean;

endmodule

`default_nettype wire

// File: hdl/rssi_aps_step_rom.sv
// Step size thresholds over the signed level difference, built at elaboration.
// Depends on rssi_aps_pkg.
`default_nettype none

module rssi_aps_step_rom #(
   parameter int SLOPE_Q8  = rssi_aps_pkg::SLOPE_Q8_DEFAULT,
   parameter int OFFSET_Q8 = rssi_aps_pkg::OFFSET_Q8_DEFAULT,
   parameter int MAX_STEP  = rssi_aps_pkg::MAX_STEP_DEFAULT
) (
   input  wire logic signed [rssi_aps_pkg::DIFF_W-1:0] diff,
   output logic             [MAX_STEP-1:0]             hit
);

   localparam longint SLOPE_DIV = (SLOPE_Q8 == 0) ? 64'sd1 : longint'(SLOPE_Q8);

   // Bit zero has no threshold.
   assign hit[0] = 1'b0;

   // Bit k is set when the exponent reaches threshold k, i.e. diff is at most the bound.
   for (genvar k = 1; k < MAX_STEP; k++) begin : g_thr
      localparam longint THR = longint'(rssi_aps_pkg::step_threshold(k));
      localparam longint NUM = longint'(10 * OFFSET_Q8) - THR;
      localparam longint QUO = (NUM >= 0) ? NUM / SLOPE_DIV
                                          : -((-NUM + SLOPE_DIV - 1) / SLOPE_DIV);
      localparam longint LIM = (QUO > 2047) ? 2047 : ((QUO < -2048) ? -2048 : QUO);
      localparam logic signed [rssi_aps_pkg::DIFF_W-1:0] BOUND =
         rssi_aps_pkg::DIFF_W'(LIM);
      if (SLOPE_Q8 == 0) begin : g_flat
         assign hit[k] = (NUM >= 0);
      end else begin : g_cmp
         assign hit[k] = (diff <= BOUND);
      end
   end

endmodule

`default_nettype wire

// File: hdl/rssi_antenna_pan_steering.sv
// An accepted item is registered in stage one, then stage two, then the result register.
// Throughput: one item per cycle; the three-stage pipeline keeps accepting while a
// result waits, and stalls only when every stage is full.
// Reset (synchronous, active high) empties the pipeline, clears both windows and
// minimums, sets the angle to 90 and the registers to their default values.
`default_nettype none
`include "rssi_antenna_pan_steering_defines.svh"

module rssi_antenna_pan_steering #(
   parameter int WINDOW    = rssi_aps_pkg::WINDOW_DEFAULT,
   parameter int SLOPE_Q8  = rssi_aps_pkg::SLOPE_Q8_DEFAULT,
   parameter int OFFSET_Q8 = rssi_aps_pkg::OFFSET_Q8_DEFAULT,
   parameter int MAX_STEP  = rssi_aps_pkg::MAX_STEP_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Input items.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // left_rssi [9:0], right_rssi [19:10], zero fill above
   input  wire logic [rssi_aps_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Result items.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // servo_angle [7:0], applied_step [16:8], left_level [26:17],
   // right_level [36:27], zero fill above
   output logic      [rssi_aps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Register writes.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [rssi_aps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rssi_aps_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int RSSI_W  = rssi_aps_pkg::RSSI_W;
   localparam int ANGLE_W = rssi_aps_pkg::ANGLE_W;
   localparam int STEP_W  = rssi_aps_pkg::STEP_W;
   localparam int DIFF_W  = rssi_aps_pkg::DIFF_W;

   // Registers.
   logic [RSSI_W-1:0]  deadband_ff;
   logic               reverse_ff;
   logic [ANGLE_W-1:0] angle_min_ff;
   logic [ANGLE_W-1:0] angle_max_ff;

   // Pipeline control.
   logic accept;
   logic out_free;
   logic s2_free;
   logic s1_free;
   logic s1_v_ff;
   logic s2_v_ff;
   logic rsp_v_ff;

   // Stage one.
   logic [RSSI_W-1:0]       left_rssi;
   logic [RSSI_W-1:0]       right_rssi;
   logic [RSSI_W-1:0]       left_prev;
   logic [RSSI_W-1:0]       right_prev;
   logic [RSSI_W-1:0]       left_move;
   logic [RSSI_W-1:0]       right_move;
   rssi_aps_pkg::steer_type steer_in;
   rssi_aps_pkg::steer_type s1_steer_ff;
   logic [RSSI_W-1:0]       left_level;
   logic [RSSI_W-1:0]       right_level;

   // Stage two.
   logic signed [DIFF_W-1:0] diff;
   logic [MAX_STEP-1:0]      hit;
   rssi_aps_pkg::steer_type  s2_steer_ff;
   logic [MAX_STEP-1:0]      s2_hit_ff;
   logic [RSSI_W-1:0]        s2_left_lvl_ff;
   logic [RSSI_W-1:0]        s2_right_lvl_ff;

   // Result stage.
   logic [STEP_W-1:0]        mag;
   logic                     negate;
   logic [STEP_W-1:0]        step;
   logic signed [ANGLE_W+1:0] angle_sum;
   logic [ANGLE_W-1:0]       angle_in;
   logic [ANGLE_W-1:0]       angle_ff;
   logic [STEP_W-1:0]        rsp_step_ff;
   logic [RSSI_W-1:0]        rsp_left_ff;
   logic [RSSI_W-1:0]        rsp_right_ff;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= '0;
         reverse_ff   <= 1'b0;
         angle_min_ff <= '0;
         angle_max_ff <= rssi_aps_pkg::ANGLE_MAX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rssi_aps_pkg::CSR_DEADBAND:  deadband_ff  <= csr_data[RSSI_W-1:0];
            rssi_aps_pkg::CSR_REVERSE:   reverse_ff   <= csr_data[0];
            rssi_aps_pkg::CSR_ANGLE_MIN: angle_min_ff <= csr_data[ANGLE_W-1:0];
            rssi_aps_pkg::CSR_ANGLE_MAX: angle_max_ff <= csr_data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Each stage moves on when the one after it is empty or moving too.
   assign out_free   = !rsp_v_ff || rsp_tready;
   assign s2_free    = !s2_v_ff || out_free;
   assign s1_free    = !s1_v_ff || s2_free;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_v_ff <= req_tvalid;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_free) begin
            rsp_v_ff <= s2_v_ff;
         end
      end
   end

   assign left_rssi  = req_tdata[RSSI_W-1:0];
   assign right_rssi = req_tdata[2*RSSI_W-1:RSSI_W];

   // Window, minimum and mean for each antenna.
   rssi_aps_channel #(
      .WINDOW (WINDOW)
   ) u_left (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .sample      (left_rssi),
      .prev_sample (left_prev),
      .level       (left_level)
   );

   rssi_aps_channel #(
      .WINDOW (WINDOW)
   ) u_right (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .sample      (right_rssi),
      .prev_sample (right_prev),
      .level       (right_level)
   );

   // Steering fires toward the stronger antenna when its sample moved past the deadband.
   assign left_move  = (left_rssi > left_prev) ? left_rssi - left_prev
                                               : left_prev - left_rssi;
   assign right_move = (right_rssi > right_prev) ? right_rssi - right_prev
                                                 : right_prev - right_rssi;

   always_comb begin
      steer_in = '0;
      if ((left_rssi > right_rssi) && (left_move > deadband_ff)) begin
         steer_in.fire = 1'b1;
         steer_in.left = 1'b1;
      end else if ((right_rssi > left_rssi) && (right_move > deadband_ff)) begin
         steer_in.fire = 1'b1;
         steer_in.left = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_steer_ff <= steer_in;
      end
   end

   // Level difference, stronger side minus weaker side, against the threshold table.
   assign diff = s1_steer_ff.left
      ? $signed(DIFF_W'(left_level)) - $signed(DIFF_W'(right_level))
      : $signed(DIFF_W'(right_level)) - $signed(DIFF_W'(left_level));

   rssi_aps_step_rom #(
      .SLOPE_Q8  (SLOPE_Q8),
      .OFFSET_Q8 (OFFSET_Q8),
      .MAX_STEP  (MAX_STEP)
   ) u_rom (
      .diff (diff),
      .hit  (hit)
   );

   always_ff @(posedge clock) begin
      if (s1_v_ff && s2_free) begin
         s2_steer_ff     <= s1_steer_ff;
         s2_hit_ff       <= hit;
         s2_left_lvl_ff  <= left_level;
         s2_right_lvl_ff <= right_level;
      end
   end

   // Step size is one plus the number of thresholds reached, signed by direction.
   assign mag    = STEP_W'(1) + STEP_W'($countones(s2_hit_ff));
   assign negate = !s2_steer_ff.left ^ reverse_ff;
   assign step   = !s2_steer_ff.fire ? '0 : (negate ? -mag : mag);

   // New angle, clamped with the lower bound taking priority.
   assign angle_sum = $signed({2'b00, angle_ff}) + $signed({step[STEP_W-1], step});

   always_comb begin
      if (angle_sum < $signed({2'b00, angle_min_ff})) begin
         angle_in = angle_min_ff;
      end else if (angle_sum > $signed({2'b00, angle_max_ff})) begin
         angle_in = angle_max_ff;
      end else begin
         angle_in = angle_sum[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= rssi_aps_pkg::ANGLE_RESET;
      end else if (s2_v_ff && out_free) begin
         angle_ff <= angle_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (s2_v_ff && out_free) begin
         rsp_step_ff  <= step;
         rsp_left_ff  <= s2_left_lvl_ff;
         rsp_right_ff <= s2_right_lvl_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {3'b000, rsp_right_ff, rsp_left_ff, rsp_step_ff, angle_ff};

   // With an empty result register the pipeline always takes a new item.
   `RAP_ASSERT_SAME(a_ready_when_out_empty, !rsp_v_ff, req_tready,
      "input stalled although the result register is empty")

   // Thresholds are nested, so the reached ones form a run from the first.
   `RAP_ASSERT_SAME(a_hit_run, s2_v_ff,
      ((s2_hit_ff >> 1) & ((s2_hit_ff >> 1) + 1'b1)) == '0,
      "threshold hits do not form a contiguous run")

   // Step size never exceeds the saturation limit.
   `RAP_ASSERT_SAME(a_step_bound, rsp_v_ff,
      (int'($signed(rsp_step_ff)) <= MAX_STEP) && (int'($signed(rsp_step_ff)) >= -MAX_STEP),
      "applied step outside the saturation limit")

   // With ordered limits the updated angle lands inside them.
   `RAP_ASSERT_NEXT(a_angle_in_limits,
      s2_v_ff && out_free && !csr_valid && (angle_min_ff <= angle_max_ff),
      (angle_ff >= angle_min_ff) && (angle_ff <= angle_max_ff),
      "servo angle outside the configured limits")

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for rssi_antenna_pan_steering: directed and random sample pairs
// under several register settings, checked against an in-bench steering predictor.
// Depends on rssi_aps_pkg for widths, register indexes and parameter defaults.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSSI_W     = rssi_aps_pkg::RSSI_W;
   localparam int ANGLE_W    = rssi_aps_pkg::ANGLE_W;
   localparam int STEP_W     = rssi_aps_pkg::STEP_W;
   localparam int REQ_DATA_W = rssi_aps_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = rssi_aps_pkg::RSP_DATA_W;
   localparam int CSR_IDX_W  = rssi_aps_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = rssi_aps_pkg::CSR_DATA_W;

   localparam int WIN       = rssi_aps_pkg::WINDOW_DEFAULT;
   localparam int SLOPE     = rssi_aps_pkg::SLOPE_Q8_DEFAULT;
   localparam int OFFSET    = rssi_aps_pkg::OFFSET_Q8_DEFAULT;
   localparam int STEP_CAP  = rssi_aps_pkg::MAX_STEP_DEFAULT;
   localparam int RSSI_TOP  = (1 << RSSI_W) - 1;
   localparam int PHASES    = 7;
   localparam int PER_PHASE = 78;

   // One input item and one result item.
   typedef struct packed {
      logic [RSSI_W-1:0] right;
      logic [RSSI_W-1:0] left;
   } rssi_pair_type;

   typedef struct packed {
      logic [RSSI_W-1:0]  right_level;
      logic [RSSI_W-1:0]  left_level;
      logic [STEP_W-1:0]  turn;
      logic [ANGLE_W-1:0] angle;
   } pan_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   rssi_antenna_pan_steering dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Stimulus and expectation stores.
   rssi_pair_type  sample_queue[$];
   pan_result_type due_results[$];
   bit          req_taken = 1'b0;
   bit          failed = 1'b0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   // Predictor state: windows, running minimums, angle and register copies.
   logic [RSSI_W-1:0]  left_hist[WIN];
   logic [RSSI_W-1:0]  right_hist[WIN];
   logic [RSSI_W-1:0]  left_low;
   logic [RSSI_W-1:0]  right_low;
   logic [ANGLE_W-1:0] pan_pos;
   logic [9:0]         cfg_deadband;
   logic               cfg_reverse;
   logic [ANGLE_W-1:0] cfg_min;
   logic [ANGLE_W-1:0] cfg_max;
   longint             exp_thr[STEP_CAP];

   initial begin
      forever #6 clock = ~clock;
   end

   // log2 in Q16; the fraction bits come from repeated squaring of the mantissa in Q30.
   function automatic int unsigned log2_fixed16(input int unsigned k);
      int unsigned     whole;
      int unsigned     bits;
      longint unsigned acc;
      whole = 0;
      while (whole < 30 && (k >> (whole + 1)) != 0) begin
         whole++;
      end
      acc = (64'(k) << (30 - whole)) & 64'h7FFF_FFFF;
      bits = 0;
      repeat (16) begin
         acc = (acc * acc) >> 30;
         bits = bits << 1;
         if (acc >= 64'h8000_0000) begin
            acc = acc >> 1;
            bits = bits | 1;
         end
      end
      return (whole << 16) | bits;
   endfunction

   // Clear the predictor to its reset state and build the exponent thresholds.
   function automatic void steer_clear();
      longint unsigned prod;
      for (int i = 0; i < WIN; i++) begin
         left_hist[i] = '0;
         right_hist[i] = '0;
      end
      left_low = '0;
      right_low = '0;
      pan_pos = rssi_aps_pkg::ANGLE_RESET;
      cfg_deadband = '0;
      cfg_reverse = 1'b0;
      cfg_min = '0;
      cfg_max = rssi_aps_pkg::ANGLE_MAX_RESET;
      exp_thr[0] = 0;
      for (int k = 1; k < STEP_CAP; k++) begin
         prod = 64'(log2_fixed16(k)) * 64'd2560 * rssi_aps_pkg::LN2_Q32;
         exp_thr[k] = longint'((prod + ((64'd1 << 48) - 64'd1)) >> 48);
      end
   endfunction

   // Step size for a signed level difference (stronger minus weaker).
   function automatic int step_size(input int diff);
      longint e;
      int     mag;
      e = 64'sd10 * OFFSET - longint'(SLOPE) * diff;
      mag = 1;
      for (int k = 1; k < STEP_CAP; k++) begin
         if (e >= exp_thr[k]) begin
            mag++;
         end
      end
      return mag;
   endfunction

   function automatic int sample_move(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Advance the steering state by one sample pair and return the result it gives.
   function automatic pan_result_type steer_update(input logic [RSSI_W-1:0] l,
                                                   input logic [RSSI_W-1:0] r);
      pan_result_type res;
      int          lprev, rprev, lsum, rsum, lmean, rmean, turn, ang;
      lprev = left_hist[WIN-1];
      rprev = right_hist[WIN-1];
      for (int i = 0; i < WIN - 1; i++) begin
         left_hist[i] = left_hist[i+1];
         right_hist[i] = right_hist[i+1];
      end
      left_hist[WIN-1] = l;
      right_hist[WIN-1] = r;
      lsum = 0;
      rsum = 0;
      for (int i = 0; i < WIN; i++) begin
         lsum += left_hist[i];
         rsum += right_hist[i];
      end
      lmean = lsum / WIN;
      rmean = rsum / WIN;

      // A zero minimum means unset, so the first sample always lands.
      if (l <= left_low || left_low == 0) begin
         left_low = l;
      end
      if (r <= right_low || right_low == 0) begin
         right_low = r;
      end
      if (lmean < left_low) begin
         lmean = left_low;
      end
      if (rmean < right_low) begin
         rmean = right_low;
      end

      // Left is tried first; right only when it is strictly stronger.
      turn = 0;
      if (l > r && sample_move(lprev, l) > cfg_deadband) begin
         turn = step_size(lmean - rmean);
      end else if (r > l && sample_move(rprev, r) > cfg_deadband) begin
         turn = -step_size(rmean - lmean);
      end
      if (cfg_reverse) begin
         turn = -turn;
      end

      // The lower bound wins when the bounds cross; the sum may go negative.
      ang = int'(pan_pos) + turn;
      if (ang < int'(cfg_min)) begin
         ang = cfg_min;
      end else if (ang > int'(cfg_max)) begin
         ang = cfg_max;
      end
      pan_pos = ang[ANGLE_W-1:0];

      res.angle = pan_pos;
      res.turn = turn[STEP_W-1:0];
      res.left_level = lmean[RSSI_W-1:0];
      res.right_level = rmean[RSSI_W-1:0];
      return res;
   endfunction

   function automatic void queue_pair(input int l, input int r);
      rssi_pair_type pr;
      pr.left = l[RSSI_W-1:0];
      pr.right = r[RSSI_W-1:0];
      sample_queue.push_back(pr);
   endfunction

   function automatic int jitter(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) begin
         v = 0;
      end else if (v > RSSI_TOP) begin
         v = RSSI_TOP;
      end
      return v;
   endfunction

   function automatic int noise_level();
      if ($urandom_range(3) == 0) begin
         return $urandom_range(1) ? RSSI_TOP : 0;
      end
      return $urandom_range(RSSI_TOP);
   endfunction

   // Directed start: empty windows, extremes, ties, a failed motion test and both
   // saturated steps driving the angle into each clamp.
   function automatic void add_directed_items();
      queue_pair(0, 0);
      queue_pair(RSSI_TOP, 0);
      queue_pair(RSSI_TOP, RSSI_TOP);
      queue_pair(0, RSSI_TOP);
      queue_pair(0, 1);
      queue_pair(1, 0);
      queue_pair(512, 512);
      queue_pair(RSSI_TOP, RSSI_TOP - 1);
      queue_pair(RSSI_TOP - 1, RSSI_TOP);
      repeat (7) queue_pair(900, 2);
      queue_pair(0, 40);
      repeat (7) queue_pair(2, 900);
      queue_pair(40, 0);
   endfunction

   // Mostly steady level runs and antenna sweeps, with some raw noise in between.
   function automatic void add_mixed_items(input int count);
      int added, kind, len, lbase, rbase, spread, hi_lvl, lo_lvl;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(9);
         if (kind < 6) begin
            lbase = $urandom_range(RSSI_TOP);
            rbase = $urandom_range(RSSI_TOP);
            spread = $urandom_range(40);
            len = $urandom_range(20, 3);
            repeat (len) queue_pair(jitter(lbase, spread), jitter(rbase, spread));
            added += len;
         end else if (kind < 8) begin
            hi_lvl = $urandom_range(RSSI_TOP, 600);
            lo_lvl = $urandom_range(200);
            len = $urandom_range(12, 2);
            repeat (len) queue_pair(jitter(hi_lvl, 8), jitter(lo_lvl, 8));
            repeat (len) queue_pair(jitter(lo_lvl, 8), jitter(hi_lvl, 8));
            added += 2 * len;
         end else begin
            len = $urandom_range(5, 1);
            repeat (len) queue_pair(noise_level(), noise_level());
            added += len;
         end
      end
   endfunction

   // One register write; the predictor copy changes when the write is taken.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rssi_aps_pkg::CSR_DEADBAND:  cfg_deadband = val[9:0];
         rssi_aps_pkg::CSR_REVERSE:   cfg_reverse = val[0];
         rssi_aps_pkg::CSR_ANGLE_MIN: cfg_min = val[ANGLE_W-1:0];
         rssi_aps_pkg::CSR_ANGLE_MAX: cfg_max = val[ANGLE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold until the block has nothing queued, in flight or owed.
   task automatic wait_drained();
      while (sample_queue.size() != 0 || req_tvalid || due_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Sender: presents the next item, or idles, once the current one is taken.
   always @(negedge clock) begin
      rssi_pair_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = sample_queue.pop_front();
            req_tdata <= REQ_DATA_W'({nxt.right, nxt.left});
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: check taken results, then predict for the item taken at this edge.
   always @(posedge clock) begin
      pan_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result item: rsp_tdata %h", rsp_tdata);
               failed = 1'b1;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[7:0] !== want.angle) begin
                  $error("servo_angle: expected %0d, got %0d", want.angle, rsp_tdata[7:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[16:8] !== want.turn) begin
                  $error("applied_step: expected %0d, got %0d",
                         $signed(want.turn), $signed(rsp_tdata[16:8]));
                  failed = 1'b1;
               end
               if (rsp_tdata[26:17] !== want.left_level) begin
                  $error("left_level: expected %0d, got %0d",
                         want.left_level, rsp_tdata[26:17]);
                  failed = 1'b1;
               end
               if (rsp_tdata[36:27] !== want.right_level) begin
                  $error("right_level: expected %0d, got %0d",
                         want.right_level, rsp_tdata[36:27]);
                  failed = 1'b1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            due_results.push_back(steer_update(req_tdata[RSSI_W-1:0],
                                               req_tdata[2*RSSI_W-1:RSSI_W]));
         end
      end
   end

   // Phase table: register settings and idling for each stretch of items.
   int ph_deadband[PHASES] = '{0, 0, 1023, 100, 5, 12, 1};
   int ph_reverse[PHASES]  = '{0, 1, 0, 0, 1, 1, 0};
   int ph_min[PHASES]      = '{0, 0, 180, 120, 30, 0, 0};
   int ph_max[PHASES]      = '{180, 180, 180, 60, 150, 180, 0};
   int ph_idle[PHASES]     = '{0, 83, 0, 35, 0, 35, 0};
   int ph_stall[PHASES]    = '{0, 0, 83, 35, 0, 35, 0};

   // Main sequence: reset, then each phase drains fully before its registers change.
   initial begin
      steer_clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         write_reg(rssi_aps_pkg::CSR_DEADBAND, ph_deadband[p]);
         write_reg(rssi_aps_pkg::CSR_REVERSE, ph_reverse[p]);
         write_reg(rssi_aps_pkg::CSR_ANGLE_MIN, ph_min[p]);
         write_reg(rssi_aps_pkg::CSR_ANGLE_MAX, ph_max[p]);
         send_idle_pct = ph_idle[p];
         rsp_stall_pct = ph_stall[p];
         if (p == 0) begin
            add_directed_items();
         end
         add_mixed_items(PER_PHASE);
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rssi_aps_pkg.sv
hdl/rssi_aps_channel.sv
hdl/rssi_aps_step_rom.sv
hdl/rssi_antenna_pan_steering.sv
test/tb.sv
